@@ src/pae_pkg.sv @@
// Shared types and constants for the positional array engine.
`timescale 1ns / 1ps

package pae_pkg;

    localparam int VAL_W  = 32;
    localparam int POS_W  = 4;
    localparam int FUNC_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR   = 3'd0,
        FN_INSERT  = 3'd1,
        FN_DELETE  = 3'd2,
        FN_REVERSE = 3'd3,
        FN_SEARCH  = 3'd4,
        FN_DISPLAY = 3'd5
    } func_t;

    // One cycle's request from the sequencer to the entry store.
    typedef struct packed {
        logic                    clr_all;
        logic                    rd_en;
        logic [POS_W-1:0]        rd_addr;
        logic                    wr_en;
        logic [POS_W-1:0]        wr_addr;
        logic signed [VAL_W-1:0] wr_data;
    } store_req_t;

endpackage

@@ src/pae_store.sv @@
// Entry store: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module pae_store
    import pae_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  store_req_t              req,
    output logic signed [VAL_W-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]        vld_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    // An entry never written since reset or clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr_all)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ src/pae_seq.sv @@
// Sequencer: steps each command through the entry store and drives the result register.
`timescale 1ns / 1ps

module pae_seq
    import pae_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [FUNC_W-1:0]       func,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] data_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] entry_value,
    output logic [POS_W-1:0]        entry_index,
    output logic                    found,
    output logic [POS_W-1:0]        found_position,
    output logic                    error,
    output logic                    last,
    output store_req_t              req,
    input  logic signed [VAL_W-1:0] rd_data
);

    localparam logic [POS_W-1:0] TOP_IDX = POS_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV_RD,
        S_MV_WR,
        S_FIN_WR,
        S_RV_RDA,
        S_RV_RDB,
        S_RV_WRA,
        S_RV_WRB,
        S_SR_RD,
        S_SR_CMP,
        S_DS_RD,
        S_DS_OUT,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [POS_W-1:0]        idx_reg, idx_next;
    logic [POS_W-1:0]        stop_reg, stop_next;
    logic                    up_reg, up_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] hold_reg, hold_next;
    logic                    rfound_reg, rfound_next;
    logic [POS_W-1:0]        rpos_reg, rpos_next;
    logic                    rerr_reg, rerr_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic [POS_W-1:0]        index_reg, index_next;
    logic                    found_reg, found_next;
    logic [POS_W-1:0]        fpos_reg, fpos_next;
    logic                    err_reg, err_next;
    logic                    last_reg, last_next;

    logic out_free;
    logic pos_ok;

    assign out_free = !out_valid_reg || out_ready;
    assign pos_ok   = (position != '0) && (position <= TOP_IDX + POS_W'(1));
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        stop_next      = stop_reg;
        up_next        = up_reg;
        key_next       = key_reg;
        hold_next      = hold_reg;
        rfound_next    = rfound_reg;
        rpos_next      = rpos_reg;
        rerr_next      = rerr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        index_next     = index_reg;
        found_next     = found_reg;
        fpos_next      = fpos_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        req            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next    = data_value;
                    rfound_next = 1'b0;
                    rpos_next   = '0;
                    rerr_next   = 1'b0;
                    case (func_t'(func))
                        FN_CLEAR:
                        begin
                            req.clr_all = 1'b1;
                            state_next  = S_RESP;
                        end
                        FN_INSERT:
                        begin
                            if (pos_ok)
                            begin
                                up_next    = 1'b1;
                                idx_next   = TOP_IDX;
                                stop_next  = position - POS_W'(1);
                                state_next = S_MV_RD;
                            end
                            else
                            begin
                                rerr_next  = 1'b1;
                                state_next = S_RESP;
                            end
                        end
                        FN_DELETE:
                        begin
                            if (pos_ok)
                            begin
                                up_next    = 1'b0;
                                idx_next   = position - POS_W'(1);
                                stop_next  = TOP_IDX;
                                state_next = S_MV_RD;
                            end
                            else
                            begin
                                rerr_next  = 1'b1;
                                state_next = S_RESP;
                            end
                        end
                        FN_REVERSE:
                        begin
                            idx_next   = '0;
                            stop_next  = TOP_IDX;
                            state_next = S_RV_RDA;
                        end
                        FN_SEARCH:
                        begin
                            idx_next   = '0;
                            state_next = S_SR_RD;
                        end
                        FN_DISPLAY:
                        begin
                            idx_next   = '0;
                            state_next = S_DS_RD;
                        end
                        default:
                        begin
                            rerr_next  = 1'b1;
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // Move one entry per S_MV_RD/S_MV_WR pair: towards the end for insert, into the deleted slot for delete.
            S_MV_RD:
            begin
                if (idx_reg == stop_reg)
                begin
                    state_next = S_FIN_WR;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = up_reg ? idx_reg - POS_W'(1) : idx_reg + POS_W'(1);
                    state_next  = S_MV_WR;
                end
            end

            S_MV_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg;
                req.wr_data = rd_data;
                idx_next    = up_reg ? idx_reg - POS_W'(1) : idx_reg + POS_W'(1);
                state_next  = S_MV_RD;
            end

            // Insert writes the new value; delete zero-fills the end.
            S_FIN_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg;
                req.wr_data = up_reg ? key_reg : '0;
                state_next  = S_RESP;
            end

            S_RV_RDA:
            begin
                if (idx_reg < stop_reg)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg;
                    state_next  = S_RV_RDB;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_RV_RDB:
            begin
                hold_next   = rd_data;
                req.rd_en   = 1'b1;
                req.rd_addr = stop_reg;
                state_next  = S_RV_WRA;
            end

            S_RV_WRA:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg;
                req.wr_data = rd_data;
                state_next  = S_RV_WRB;
            end

            S_RV_WRB:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = stop_reg;
                req.wr_data = hold_reg;
                idx_next    = idx_reg + POS_W'(1);
                stop_next   = stop_reg - POS_W'(1);
                state_next  = S_RV_RDA;
            end

            S_SR_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx_reg;
                state_next  = S_SR_CMP;
            end

            S_SR_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    rfound_next = 1'b1;
                    rpos_next   = idx_reg + POS_W'(1);
                    state_next  = S_RESP;
                end
                else if (idx_reg == TOP_IDX)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + POS_W'(1);
                    state_next = S_SR_RD;
                end
            end

            S_DS_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx_reg;
                state_next  = S_DS_OUT;
            end

            // Hold the read data until the result register frees up.
            S_DS_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = rd_data;
                    index_next     = idx_reg;
                    found_next     = 1'b0;
                    fpos_next      = '0;
                    err_next       = 1'b0;
                    last_next      = (idx_reg == TOP_IDX);
                    if (idx_reg == TOP_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + POS_W'(1);
                        state_next = S_DS_RD;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = '0;
                    index_next     = '0;
                    found_next     = rfound_reg;
                    fpos_next      = rpos_reg;
                    err_next       = rerr_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            stop_reg      <= '0;
            up_reg        <= 1'b0;
            rfound_reg    <= 1'b0;
            rpos_reg      <= '0;
            rerr_reg      <= 1'b0;
            key_reg       <= '0;
            hold_reg      <= '0;
            value_reg     <= '0;
            index_reg     <= '0;
            found_reg     <= 1'b0;
            fpos_reg      <= '0;
            err_reg       <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            stop_reg      <= stop_next;
            up_reg        <= up_next;
            rfound_reg    <= rfound_next;
            rpos_reg      <= rpos_next;
            rerr_reg      <= rerr_next;
            key_reg       <= key_next;
            hold_reg      <= hold_next;
            value_reg     <= value_next;
            index_reg     <= index_next;
            found_reg     <= found_next;
            fpos_reg      <= fpos_next;
            err_reg       <= err_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign entry_value    = value_reg;
    assign entry_index    = index_reg;
    assign found          = found_reg;
    assign found_position = fpos_reg;
    assign error          = err_reg;
    assign last           = last_reg;

    a_no_clr_with_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.clr_all && req.wr_en))
        else $error("clear and write issued together");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (index_reg <= TOP_IDX))
        else $error("displayed index beyond array");

    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg) |-> (!found_reg && last_reg))
        else $error("error result carries a match or no last mark");

    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (fpos_reg != '0 && fpos_reg <= TOP_IDX + POS_W'(1)))
        else $error("match position out of range");

    a_busy_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.clr_all)
        else $error("clear issued mid-command");

endmodule

@@ src/positional_array_engine.sv @@
// Clear or a rejected command goes straight to the result; insert and delete shift entries with
// a read and a write each; reverse swaps pairs from both ends; search and display read in order.
// One command at a time: a single entry-store read port and write port carry every move,
// swap, compare and display step, and the input is not ready until the command ends.
// Results leave through an output register, so the next command starts while one waits.
// Reset (asynchronous, active low) empties the output register and makes every entry read zero.
`timescale 1ns / 1ps

module positional_array_engine
    import pae_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [FUNC_W-1:0]       func,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] data_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] entry_value,
    output logic [POS_W-1:0]        entry_index,
    output logic                    found,
    output logic [POS_W-1:0]        found_position,
    output logic                    error,
    output logic                    last
);

    store_req_t              req;
    logic signed [VAL_W-1:0] rd_data;

    pae_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .position       (position),
        .data_value     (data_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .entry_value    (entry_value),
        .entry_index    (entry_index),
        .found          (found),
        .found_position (found_position),
        .error          (error),
        .last           (last),
        .req            (req),
        .rd_data        (rd_data)
    );

    pae_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

endmodule
